[hw/rtl/sgdm_pkg.sv]
package sgdm_pkg;

    localparam int ADDR_W             = 12;
    localparam int DATA_W             = 32;
    localparam int SUM_W              = 40;
    localparam int COEF_W             = 16;
    localparam int CFG_IDX_W          = 8;
    localparam int FRAC_BITS          = 16;
    localparam int VELOCITY_DEPTH_DEF = 4096;

    // multiplier operands: unsigned Q1.16 times signed Q16.16
    localparam int MUL_A_W    = COEF_W + 1;
    localparam int MUL_P_W    = MUL_A_W + 1 + DATA_W;
    localparam int MUL_FLR_W  = MUL_P_W - FRAC_BITS;

    localparam logic [COEF_W-1:0]  LR_RESET   = 16'd655;
    localparam logic [COEF_W-1:0]  BETA_RESET = 16'd58982;
    localparam logic [MUL_A_W-1:0] ONE_Q16    = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM_BETA = 8'd1;

    typedef struct packed {
        logic wr;
        logic rd;
    } vmem_ctl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W:0] x);
        logic signed [SUM_W:0] hi;
        logic signed [SUM_W:0] lo;
        hi = 41'sh00_7FFF_FFFF;
        lo = -41'sh00_8000_0000;
        if (x > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < lo)
        begin
            return 32'sh8000_0000;
        end
        return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat40(input logic signed [SUM_W:0] x);
        if (x[SUM_W] != x[SUM_W-1])
        begin
            return x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return x[SUM_W-1:0];
    endfunction

endpackage

[hw/rtl/sgdm_mul.sv]
module sgdm_mul
    import sgdm_pkg::*;
(
    input  logic                        clk,
    input  logic                        start,
    input  logic [MUL_A_W-1:0]          op_a,
    input  logic signed [DATA_W-1:0]    op_b,
    output logic signed [MUL_FLR_W-1:0] prod_floor
);

    logic signed [MUL_P_W-1:0] prod_full;
    logic signed [MUL_P_W-1:0] prod_reg;

    assign prod_full = $signed({1'b0, op_a}) * op_b;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_full;
        end
    end

    // dropping the fraction bits of a two's complement value rounds toward minus infinity
    assign prod_floor = prod_reg[MUL_P_W-1:FRAC_BITS];

endmodule

[hw/rtl/sgdm_vmem.sv]
module sgdm_vmem
    import sgdm_pkg::*;
#(
    parameter int DEPTH = VELOCITY_DEPTH_DEF,
    parameter int AW    = 12
)
(
    input  logic                     clk,
    input  vmem_ctl_t                ctl,
    input  logic [AW-1:0]            addr,
    input  logic signed [DATA_W-1:0] wdata,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sgd_momentum_lane_sum_update.sv]
// sgd momentum update, one weight element per group of lane transactions
// input channel: one transaction per batch lane carrying velocity_address, lane_gradient,
// current_weight and last_lane; gradients add into a 40-bit saturating lane sum
// a transaction without last_lane only adds into the lane sum and produces nothing
// a transaction with last_lane runs the velocity update through one shared
// 17x32 multiplier: three products, each registered, plus a velocity memory
// read and write-back, in the states S_READ, S_MUL_BV, S_MUL_G, S_VEL, S_MUL_LR
// and S_WGT, after which out_valid rises; when the address is at or above
// VELOCITY_DEPTH it is first wrapped by a reciprocal multiply and a subtract
// (S_MOD, S_WRAP); the input channel is stalled while that sequence runs, so the
// next transaction is taken in the cycle after the result is loaded at the earliest
// output channel: element_address and new_weight sit in an output register;
// non-last transactions are still taken while a result waits there, and a
// finished update waits for the register to drain when the receiver stalls
// config channel: cfg_ready is always high, index 0 is learning_rate, index 1
// is momentum_beta, other indexes are dropped
// after reset the velocity memory is swept to zero, one entry per cycle, over all
// VELOCITY_DEPTH entries, with the input channel stalled
module sgd_momentum_lane_sum_update
    import sgdm_pkg::*;
#(
    parameter int VELOCITY_DEPTH = VELOCITY_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ADDR_W-1:0]        velocity_address,
    input  logic signed [DATA_W-1:0] lane_gradient,
    input  logic signed [DATA_W-1:0] current_weight,
    input  logic                     last_lane,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ADDR_W-1:0]        element_address,
    output logic signed [DATA_W-1:0] new_weight
);

    localparam int IDX_W           = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
    localparam int EXT_W           = 33;
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(VELOCITY_DEPTH);
    localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(VELOCITY_DEPTH - 1);
    // (x * RECIP) >> RECIP_SHIFT equals x / VELOCITY_DEPTH for every 12-bit x
    localparam int RECIP_SHIFT     = ADDR_W + IDX_W;
    localparam int RECIP_W         = ADDR_W + 2;
    localparam int QPROD_W         = ADDR_W + RECIP_W;
    localparam longint RECIP_FULL  = ((longint'(1) <<< RECIP_SHIFT) + longint'(VELOCITY_DEPTH) - 1)
                                     / longint'(VELOCITY_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);
    localparam logic [ADDR_W-1:0]  DEPTH_ADDR = ADDR_W'(VELOCITY_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_WRAP,
        S_READ,
        S_MUL_BV,
        S_MUL_G,
        S_VEL,
        S_MUL_LR,
        S_WGT
    } state_t;

    state_t                   state_reg, state_next;
    logic [COEF_W-1:0]        lr_reg, lr_next;
    logic [COEF_W-1:0]        beta_reg, beta_next;
    logic signed [SUM_W-1:0]  lane_sum_reg, lane_sum_next;
    logic [IDX_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                     out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]        rem_reg, rem_next;
    logic [ADDR_W-1:0]        quo_reg, quo_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic signed [DATA_W-1:0] weight_reg, weight_next;
    logic signed [DATA_W-1:0] g_reg, g_next;
    logic signed [MUL_FLR_W-1:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic [ADDR_W-1:0]        element_address_reg, element_address_next;
    logic signed [DATA_W-1:0] new_weight_reg, new_weight_next;

    logic                     in_acc;
    logic                     out_free;
    logic signed [SUM_W:0]    sum_wide;
    logic [EXT_W-1:0]         rem_ext;
    logic [EXT_W-1:0]         addr_ext;
    logic [QPROD_W-1:0]       quo_prod;
    logic [QPROD_W-1:0]       quo_full;
    logic [ADDR_W-1:0]        wrap_sub;
    logic signed [MUL_FLR_W+1:0] vel_sum;
    logic signed [MUL_FLR_W-1:0] wgt_sum;

    logic                        mul_start;
    logic [MUL_A_W-1:0]          mul_a;
    logic signed [DATA_W-1:0]    mul_b;
    logic signed [MUL_FLR_W-1:0] prod_floor;

    vmem_ctl_t                vmem_ctl;
    logic [IDX_W-1:0]         vmem_addr;
    logic signed [DATA_W-1:0] vmem_wdata;
    logic signed [DATA_W-1:0] vmem_rdata;

    sgdm_mul u_mul (
        .clk        (clk),
        .start      (mul_start),
        .op_a       (mul_a),
        .op_b       (mul_b),
        .prod_floor (prod_floor)
    );

    sgdm_vmem #(
        .DEPTH (VELOCITY_DEPTH),
        .AW    (IDX_W)
    ) u_vmem (
        .clk   (clk),
        .ctl   (vmem_ctl),
        .addr  (vmem_addr),
        .wdata (vmem_wdata),
        .rdata (vmem_rdata)
    );

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign element_address = element_address_reg;
    assign new_weight      = new_weight_reg;

    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign sum_wide = (SUM_W+1)'(lane_sum_reg) + (SUM_W+1)'(lane_gradient);
    assign rem_ext  = EXT_W'(rem_reg);
    assign addr_ext = EXT_W'(velocity_address);
    assign quo_prod = QPROD_W'(rem_reg) * QPROD_W'(RECIP);
    assign quo_full = quo_prod >> RECIP_SHIFT;
    assign wrap_sub = quo_reg * DEPTH_ADDR;
    assign vel_sum  = (MUL_FLR_W+2)'(acc_reg) + (MUL_FLR_W+2)'(prod_floor);
    assign wgt_sum  = MUL_FLR_W'(weight_reg) - prod_floor;

    assign vmem_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : rem_ext[IDX_W-1:0];
    assign vmem_wdata = (state_reg == S_CLEAR) ? '0 : v_next;

    always_comb
    begin
        state_next           = state_reg;
        lr_next              = lr_reg;
        beta_next            = beta_reg;
        lane_sum_next        = lane_sum_reg;
        clr_cnt_next         = clr_cnt_reg;
        out_valid_next       = out_valid_reg;
        rem_next             = rem_reg;
        quo_next             = quo_reg;
        addr_next            = addr_reg;
        weight_next          = weight_reg;
        g_next               = g_reg;
        acc_next             = acc_reg;
        v_next               = v_reg;
        element_address_next = element_address_reg;
        new_weight_next      = new_weight_reg;
        vmem_ctl             = '{wr: 1'b0, rd: 1'b0};
        mul_start            = 1'b0;
        mul_a                = {1'b0, beta_reg};
        mul_b                = vmem_rdata;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEARNING_RATE: lr_next   = cfg_data;
                CFG_MOMENTUM_BETA: beta_next = cfg_data;
                default:           ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                vmem_ctl.wr  = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (last_lane)
                    begin
                        lane_sum_next = '0;
                        g_next        = sat32(sum_wide);
                        addr_next     = velocity_address;
                        weight_next   = current_weight;
                        rem_next      = velocity_address;
                        state_next    = (addr_ext >= DEPTH_EXT) ? S_MOD : S_READ;
                    end
                    else
                    begin
                        lane_sum_next = sat40(sum_wide);
                    end
                end
            end
            S_MOD:
            begin
                // quotient by depth through the constant reciprocal
                quo_next   = quo_full[ADDR_W-1:0];
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                rem_next   = rem_reg - wrap_sub;
                state_next = S_READ;
            end
            S_READ:
            begin
                vmem_ctl.rd = 1'b1;
                state_next  = S_MUL_BV;
            end
            S_MUL_BV:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, beta_reg};
                mul_b      = vmem_rdata;
                state_next = S_MUL_G;
            end
            S_MUL_G:
            begin
                acc_next   = prod_floor;
                mul_start  = 1'b1;
                mul_a      = ONE_Q16 - {1'b0, beta_reg};
                mul_b      = g_reg;
                state_next = S_VEL;
            end
            S_VEL:
            begin
                v_next      = sat32((SUM_W+1)'(vel_sum));
                vmem_ctl.wr = 1'b1;
                state_next  = S_MUL_LR;
            end
            S_MUL_LR:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, lr_reg};
                mul_b      = v_reg;
                state_next = S_WGT;
            end
            S_WGT:
            begin
                if (out_free)
                begin
                    element_address_next = addr_reg;
                    new_weight_next      = sat32((SUM_W+1)'(wgt_sum));
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lr_reg        <= LR_RESET;
            beta_reg      <= BETA_RESET;
            lane_sum_reg  <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lr_reg        <= lr_next;
            beta_reg      <= beta_next;
            lane_sum_reg  <= lane_sum_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg             <= rem_next;
        quo_reg             <= quo_next;
        addr_reg            <= addr_next;
        weight_reg          <= weight_next;
        g_reg               <= g_next;
        acc_reg             <= acc_next;
        v_reg               <= v_next;
        element_address_reg <= element_address_next;
        new_weight_reg      <= new_weight_next;
    end

`ifndef SYNTHESIS
    a_last_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_lane |=> lane_sum_reg == '0)
        else $error("lane sum not cleared after last lane");

    a_last_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_lane |=> state_reg == S_MOD || state_reg == S_READ)
        else $error("last lane did not start an update");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> rem_ext < DEPTH_EXT)
        else $error("velocity index not reduced below depth");

    a_mem_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        vmem_ctl.wr |-> state_reg == S_CLEAR || state_reg == S_VEL)
        else $error("velocity write outside clear or update");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WGT && out_free |=> out_valid && state_reg == S_IDLE)
        else $error("finished update not presented");
`endif

endmodule

[tb/sgd_momentum_lane_sum_update_test.sv]
module sgd_momentum_lane_sum_update_test;
    import sgdm_pkg::*;

    localparam int DEPTH = VELOCITY_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX   = 8'hFF;

    localparam logic signed [DATA_W-1:0] GRAD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] GRAD_MIN = 32'sh8000_0000;

    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint W_HI   = 64'sd2147483647;
    localparam longint W_LO   = -W_HI - 1;

    typedef enum int {GRAD_SMALL, GRAD_WIDE, GRAD_EDGE} grad_mode_t;

    class weight_update_predictor;
        typedef struct {
            logic [ADDR_W-1:0]        addr;
            logic signed [DATA_W-1:0] weight;
        } weight_update_t;

        logic [COEF_W-1:0]        learning_rate;
        logic [COEF_W-1:0]        momentum_beta;
        logic signed [SUM_W-1:0]  lane_total;
        logic signed [DATA_W-1:0] velocity [DEPTH];
        weight_update_t           expected_weights [$];
        int                       mismatches;

        function new();
            learning_rate = LR_RESET;
            momentum_beta = BETA_RESET;
            lane_total = '0;
            foreach (velocity[i])
            begin
                velocity[i] = '0;
            end
            mismatches = 0;
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            if (x < lo)
            begin
                return lo;
            end
            if (x > hi)
            begin
                return hi;
            end
            return x;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_LEARNING_RATE: learning_rate = data;
                CFG_MOMENTUM_BETA: momentum_beta = data;
                default: ;
            endcase
        endfunction

        function void take_gradient(logic [ADDR_W-1:0] addr, logic signed [DATA_W-1:0] grad,
                                    logic signed [DATA_W-1:0] weight, logic last);
            longint         total;
            longint         g;
            longint         v_old;
            longint         v_new;
            longint         w;
            int             slot;
            weight_update_t upd;
            total = clip(longint'(lane_total) + longint'(grad), SUM_LO, SUM_HI);
            lane_total = total[SUM_W-1:0];
            if (!last)
            begin
                return;
            end
            g = clip(longint'(lane_total), W_LO, W_HI);
            lane_total = '0;
            slot = addr % DEPTH;
            v_old = longint'(velocity[slot]);
            // shifts on longint are arithmetic, so they floor
            v_new = ((longint'(momentum_beta) * v_old) >>> FRAC_BITS)
                  + ((((longint'(1) <<< FRAC_BITS) - longint'(momentum_beta)) * g) >>> FRAC_BITS);
            v_new = clip(v_new, W_LO, W_HI);
            velocity[slot] = v_new[DATA_W-1:0];
            w = clip(longint'(weight) - ((longint'(learning_rate) * v_new) >>> FRAC_BITS),
                     W_LO, W_HI);
            upd.addr = addr;
            upd.weight = w[DATA_W-1:0];
            expected_weights.push_back(upd);
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void check_weight(logic [ADDR_W-1:0] addr, logic signed [DATA_W-1:0] weight);
            weight_update_t want;
            if (expected_weights.size() == 0)
            begin
                note_error($sformatf("unexpected transaction: addr %0d weight %0d",
                                     addr, weight));
                return;
            end
            want = expected_weights.pop_front();
            if (addr !== want.addr)
            begin
                note_error($sformatf("element_address: expected %0d actual %0d",
                                     want.addr, addr));
            end
            if (weight !== want.weight)
            begin
                note_error($sformatf("new_weight at %0d: expected %0d actual %0d",
                                     want.addr, want.weight, weight));
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [COEF_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [ADDR_W-1:0]        velocity_address;
    logic signed [DATA_W-1:0] lane_gradient;
    logic signed [DATA_W-1:0] current_weight;
    logic                     last_lane;
    logic                     out_valid;
    logic                     out_stall;
    logic [ADDR_W-1:0]        element_address;
    logic signed [DATA_W-1:0] new_weight;

    weight_update_predictor book;
    bit valid_up = 1'b0;
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;

    sgd_momentum_lane_sum_update uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .velocity_address (velocity_address),
        .lane_gradient    (lane_gradient),
        .current_weight   (current_weight),
        .last_lane        (last_lane),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .element_address  (element_address),
        .new_weight       (new_weight)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_gradient(grad_mode_t mode);
        case (mode)
            GRAD_SMALL: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
            GRAD_WIDE:  return $urandom;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return GRAD_MAX;
                    1: return GRAD_MIN;
                    2: return 32'sd1;
                    3: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return $urandom;
        end
        if (r < 9)
        begin
            return int'($urandom_range(0, 1 << 22)) - (1 << 21);
        end
        return r[0] ? GRAD_MAX : GRAD_MIN;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        // a small pool of elements so velocities build up over many updates
        if (r < 60)
        begin
            return ADDR_W'($urandom_range(0, 15));
        end
        if (r < 75)
        begin
            return ADDR_W'($urandom_range(DEPTH - 8, DEPTH - 1));
        end
        return ADDR_W'($urandom_range(0, DEPTH - 1));
    endfunction

    task automatic send_lane(input logic [ADDR_W-1:0] addr, input logic signed [DATA_W-1:0] grad,
                             input logic signed [DATA_W-1:0] weight, input logic last);
        int gap;
        in_valid <= 1'b1;
        valid_up = 1'b1;
        velocity_address <= addr;
        lane_gradient <= grad;
        current_weight <= weight;
        last_lane <= last;
        do
            @(posedge clk);
        while (in_stall);
        book.take_gradient(addr, grad, weight, last);
        gap = pick_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // non-last lanes carry random address and weight, which the block ignores
    task automatic send_group(input logic [ADDR_W-1:0] addr, input int lanes,
                              input grad_mode_t mode);
        for (int i = 0; i < lanes; i++)
        begin
            if (i == lanes - 1)
            begin
                send_lane(addr, pick_gradient(mode), pick_weight(), 1'b1);
            end
            else
            begin
                send_lane(ADDR_W'($urandom_range(0, DEPTH - 1)), pick_gradient(mode),
                          pick_weight(), 1'b0);
            end
        end
    endtask

    task automatic quiesce();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (book.expected_weights.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.write_reg(idx, data);
    endtask

    task automatic set_rates(input logic [COEF_W-1:0] lr, input logic [COEF_W-1:0] beta);
        write_reg(CFG_LEARNING_RATE, lr);
        write_reg(CFG_MOMENTUM_BETA, beta);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        int         count;
        int         lanes;
        int         r;
        grad_mode_t mode;
        count = 0;
        while (count < items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                in_calm = ~in_calm;
            end
            r = $urandom_range(0, 99);
            lanes = (r < 70) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 16)
                                                                : $urandom_range(17, 40);
            r = $urandom_range(0, 99);
            mode = (r < 50) ? GRAD_SMALL : (r < 85) ? GRAD_WIDE : GRAD_EDGE;
            send_group(pick_address(), lanes, mode);
            count += lanes;
        end
    endtask

    // receiver side: random stall windows, with stretches of none
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                out_calm = ~out_calm;
            end
            n = pick_gap(out_calm);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            book.check_weight(element_address, new_weight);
        end
    end

    initial
    begin
        #20_000_000;
        $display("sgd_momentum_lane_sum_update test failed");
        $finish;
    end

    initial
    begin
        book = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        velocity_address = '0;
        lane_gradient = '0;
        current_weight = '0;
        last_lane = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset rates: single lane, field extremes, 32-bit sum saturation
        send_lane(12'd0, 32'sd0, 32'sd0, 1'b1);
        send_lane(12'd4095, GRAD_MAX, GRAD_MAX, 1'b1);
        send_lane(12'd4095, GRAD_MIN, GRAD_MIN, 1'b1);
        send_lane(12'd77, GRAD_MAX, GRAD_MIN, 1'b0);
        send_lane(12'd1, GRAD_MAX, GRAD_MAX, 1'b1);
        send_lane(12'd3000, GRAD_MIN, GRAD_MAX, 1'b0);
        send_lane(12'd1, GRAD_MIN, GRAD_MIN, 1'b1);
        send_lane(12'd9, 32'sd1, 32'sd0, 1'b0);
        send_lane(12'd9, -32'sd1, 32'sd0, 1'b0);
        send_lane(12'd2, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
        quiesce();

        // full step, no momentum: weight saturates both ways
        set_rates(16'hFFFF, 16'h0000);
        send_lane(12'd1, GRAD_MIN, GRAD_MAX, 1'b1);
        send_lane(12'd2, GRAD_MAX, GRAD_MIN, 1'b1);
        send_lane(12'd4095, -32'sd1, 32'sd0, 1'b1);
        quiesce();

        // no step, full momentum
        set_rates(16'h0000, 16'hFFFF);
        send_lane(12'd1, GRAD_MAX, 32'sd12345, 1'b1);
        send_lane(12'd2, GRAD_MIN, -32'sd12345, 1'b1);
        quiesce();

        // lane sum driven past the 40-bit range in both directions
        set_rates(LR_RESET, BETA_RESET);
        for (int i = 0; i < 260; i++)
        begin
            send_lane(ADDR_W'($urandom_range(0, DEPTH - 1)), GRAD_MAX, pick_weight(), 1'b0);
        end
        send_lane(12'd3, GRAD_MAX, 32'sd0, 1'b1);
        for (int i = 0; i < 260; i++)
        begin
            send_lane(ADDR_W'($urandom_range(0, DEPTH - 1)), GRAD_MIN, pick_weight(), 1'b0);
        end
        send_lane(12'd3, GRAD_MIN, 32'sd0, 1'b1);
        quiesce();

        random_phase(30);
        quiesce();
        set_rates(16'hFFFF, 16'h0000);
        random_phase(30);
        quiesce();
        set_rates(16'h0000, 16'hFFFF);
        random_phase(30);
        quiesce();
        // unused indexes must leave both rates alone
        write_reg(CFG_LEARNING_RATE, COEF_W'($urandom_range(0, 65535)));
        write_reg(CFG_MOMENTUM_BETA, COEF_W'($urandom_range(50000, 65535)));
        write_reg(CFG_SPARE_INDEX, COEF_W'($urandom_range(0, 65535)));
        write_reg(CFG_TOP_INDEX, COEF_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        random_phase(30);
        quiesce();
        set_rates(COEF_W'($urandom_range(0, 65535)), COEF_W'($urandom_range(0, 65535)));
        random_phase(30);
        quiesce();

        if (book.mismatches == 0 && book.expected_weights.size() == 0)
        begin
            $display("sgd_momentum_lane_sum_update test passed");
        end
        else
        begin
            $display("sgd_momentum_lane_sum_update test failed");
        end
        $finish;
    end

endmodule
